FILE: sv/eras_pkg.sv
// Shared types and constants for the extended register ALU and store unit.
package eras_pkg;

  localparam int NUM_REGS = 8;
  localparam int RIDX_W   = 3;

  typedef enum logic [1:0] {
    FUNC_LOGIC = 2'd0,
    FUNC_MATH  = 2'd1,
    FUNC_STORE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // logic group modes
  localparam logic [1:0] LOG_MOVE = 2'd0;
  localparam logic [1:0] LOG_XOR  = 2'd1;
  localparam logic [1:0] LOG_AND  = 2'd2;
  localparam logic [1:0] LOG_OR   = 2'd3;

  // store group modes
  localparam logic [1:0] ST_ZP_DS = 2'd0;
  localparam logic [1:0] ST_W_DS  = 2'd1;
  localparam logic [1:0] ST_W_SEG = 2'd2;
  localparam logic [1:0] ST_W_SS  = 2'd3;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic o;
  } flags_t;

  typedef struct packed {
    logic        reg_write_valid;
    logic [15:0] result_value;
    logic        mem_write_valid;
    logic [7:0]  mem_seg;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    flags_t      flags;
  } result_t;

endpackage

FILE: sv/eras_regfile.sv
// Eight-entry register file: sync read on two ports, write-first bypass, valid bits.
module eras_regfile #(
  parameter int W = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [eras_pkg::RIDX_W-1:0] raddr_a,
  input  logic [eras_pkg::RIDX_W-1:0] raddr_b,
  output logic [W-1:0]               rdata_a,
  output logic [W-1:0]               rdata_b,
  input  logic                       wr_en,
  input  logic [eras_pkg::RIDX_W-1:0] waddr,
  input  logic [W-1:0]               wdata
);
  import eras_pkg::*;

  logic [W-1:0]        mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && waddr == raddr_a) begin
        rdata_a <= wdata;
      end else begin
        rdata_a <= vld[raddr_a] ? mem[raddr_a] : '0;
      end
      if (wr_en && waddr == raddr_b) begin
        rdata_b <= wdata;
      end else begin
        rdata_b <= vld[raddr_b] ? mem[raddr_b] : '0;
      end
    end
  end

endmodule

FILE: sv/eras_exec.sv
// Execute logic: logic, add/subtract and store address groups, flag update.
module eras_exec #(
  parameter int W = 16
) (
  input  logic [1:0]             func,
  input  logic [7:0]             opcode,
  input  logic [15:0]            constant_word,
  input  logic [7:0]             segment_byte,
  input  logic [7:0]             data_seg,
  input  logic [7:0]             stack_seg,
  input  logic [W-1:0]           vd,
  input  logic [W-1:0]           vs,
  input  eras_pkg::flags_t       flags_in,
  output eras_pkg::result_t      res,
  output logic [W-1:0]           wdata
);
  import eras_pkg::*;

  localparam int XW = (W > 16) ? W : 16;
  localparam int UW = XW + 2;

  logic [1:0]          mode;
  logic                same;
  logic [W-1:0]        sterm;
  logic [15:0]         con16;
  logic [W-1:0]        conw;
  logic [UW-1:0]       add_u;
  logic [UW-1:0]       sub_t;
  logic [UW-1:0]       sub_u;
  logic signed [W+1:0] s_d;
  logic signed [W+1:0] s_s;
  logic signed [W+1:0] s_c;
  logic signed [W+1:0] s_res;
  logic [W-1:0]        r;
  logic [XW-1:0]       r_ext;
  logic [15:0]         base;
  logic [15:0]         idx;

  assign mode  = opcode[7:6];
  assign same  = (opcode[5:3] == opcode[2:0]);
  assign sterm = same ? '0 : vs;
  assign con16 = opcode[7] ? constant_word : 16'd0;
  assign conw  = W'(con16);

  assign add_u = UW'(vd) + UW'(sterm) + UW'(con16);
  assign sub_t = UW'(sterm) + UW'(con16);
  assign sub_u = UW'(vd) - sub_t;

  assign s_d   = {{2{vd[W-1]}}, vd};
  assign s_s   = {{2{sterm[W-1]}}, sterm};
  assign s_c   = {{2{conw[W-1]}}, conw};
  assign s_res = opcode[6] ? (s_d - s_s - s_c) : (s_d + s_s + s_c);

  assign idx   = {{8{vd[7]}}, vd[7:0]};

  always_comb begin
    r     = '0;
    base  = '0;
    res   = '0;
    res.flags = flags_in;
    unique case (func_t'(func))
      FUNC_LOGIC: begin
        unique case (mode)
          LOG_MOVE: r = same ? ~vs : vs;
          LOG_XOR:  r = vs ^ vd;
          LOG_AND:  r = vs & vd;
          LOG_OR:   r = vs | vd;
          default:  r = vs;
        endcase
        res.reg_write_valid = 1'b1;
        res.flags.n = r[W-1];
        res.flags.z = (r == '0);
      end
      FUNC_MATH: begin
        if (opcode[6]) begin
          r = sub_u[W-1:0];
          res.flags.c = (UW'(vd) >= sub_t);
        end else begin
          r = add_u[W-1:0];
          res.flags.c = |add_u[UW-1:W];
        end
        // signed overflow: top three bits of the exact result disagree
        res.flags.o = !((s_res[W+1:W-1] == 3'b000) || (s_res[W+1:W-1] == 3'b111));
        res.reg_write_valid = 1'b1;
        res.flags.n = r[W-1];
        res.flags.z = (r == '0);
      end
      FUNC_STORE: begin
        unique case (mode)
          ST_ZP_DS: begin
            res.mem_seg = data_seg;
            base        = {8'd0, constant_word[7:0]};
          end
          ST_W_DS: begin
            res.mem_seg = data_seg;
            base        = constant_word;
          end
          ST_W_SEG: begin
            res.mem_seg = segment_byte;
            base        = constant_word;
          end
          ST_W_SS: begin
            res.mem_seg = stack_seg;
            base        = constant_word;
          end
          default: begin
            res.mem_seg = data_seg;
            base        = constant_word;
          end
        endcase
        res.mem_addr        = same ? base : base + idx;
        res.mem_data        = vs[7:0];
        res.mem_write_valid = 1'b1;
      end
      FUNC_NONE: begin
        r = '0;
      end
      default: begin
        r = '0;
      end
    endcase
    r_ext = XW'(r);
    res.result_value = res.reg_write_valid ? r_ext[15:0] : 16'd0;
  end

  assign wdata = r;

endmodule

FILE: sv/extended_register_alu_and_store.sv
// Top level: two-stage execute unit around a synchronous register file.
// Flow: an accepted input beat enters the execute stage; its result is registered
//   into the output when execute advances. Throughput: one instruction per cycle
//   while the output drains; RF reads are registered, and same-edge writes are bypassed.
// Reset: clears the pipeline valids, the status flags and the register valid
//   bits, so every register reads as zero until first written.
module extended_register_alu_and_store #(
  parameter int REG_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  opcode,
  input  logic [15:0] constant_word,
  input  logic [7:0]  segment_byte,
  input  logic [7:0]  data_seg,
  input  logic [7:0]  stack_seg,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        reg_write_valid,
  output logic [15:0] result_value,
  output logic        mem_write_valid,
  output logic [7:0]  mem_seg,
  output logic [15:0] mem_addr,
  output logic [7:0]  mem_data,
  output logic        flag_negative,
  output logic        flag_zero,
  output logic        flag_carry,
  output logic        flag_overflow
);
  import eras_pkg::*;

  // execute stage: holds the instruction while its operands come out of the RF
  logic        ex_valid;
  logic [1:0]  ex_func;
  logic [7:0]  ex_opcode;
  logic [15:0] ex_const;
  logic [7:0]  ex_segb;
  logic [7:0]  ex_ds;
  logic [7:0]  ex_ss;

  logic in_beat;
  logic ex_adv;

  logic [REG_WIDTH-1:0] vd;
  logic [REG_WIDTH-1:0] vs;
  logic [REG_WIDTH-1:0] wdata;

  flags_t  flags;
  result_t ex_res;
  result_t out_res;

  // execute moves on when the output register is empty or being drained
  assign ex_adv   = ex_valid && (!out_valid || out_ready);
  assign in_ready = !ex_valid || ex_adv;
  assign in_beat  = in_valid && in_ready;

  // port A reads the destination/index register, port B the source
  eras_regfile #(
    .W (REG_WIDTH)
  ) u_rf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_beat),
    .raddr_a (opcode[5:3]),
    .raddr_b (opcode[2:0]),
    .rdata_a (vd),
    .rdata_b (vs),
    .wr_en   (ex_adv && ex_res.reg_write_valid),
    .waddr   (ex_opcode[5:3]),
    .wdata   (wdata)
  );

  eras_exec #(
    .W (REG_WIDTH)
  ) u_exec (
    .func          (ex_func),
    .opcode        (ex_opcode),
    .constant_word (ex_const),
    .segment_byte  (ex_segb),
    .data_seg      (ex_ds),
    .stack_seg     (ex_ss),
    .vd            (vd),
    .vs            (vs),
    .flags_in      (flags),
    .res           (ex_res),
    .wdata         (wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (in_ready) begin
      ex_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      ex_func   <= func;
      ex_opcode <= opcode;
      ex_const  <= constant_word;
      ex_segb   <= segment_byte;
      ex_ds     <= data_seg;
      ex_ss     <= stack_seg;
    end
  end

  // flags commit with the instruction, so the next one sees them at once
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (ex_adv) begin
      flags <= ex_res.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ex_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_adv) begin
      out_res <= ex_res;
    end
  end

  assign reg_write_valid = out_res.reg_write_valid;
  assign result_value    = out_res.result_value;
  assign mem_write_valid = out_res.mem_write_valid;
  assign mem_seg         = out_res.mem_seg;
  assign mem_addr        = out_res.mem_addr;
  assign mem_data        = out_res.mem_data;
  assign flag_negative   = out_res.flags.n;
  assign flag_zero       = out_res.flags.z;
  assign flag_carry      = out_res.flags.c;
  assign flag_overflow   = out_res.flags.o;

endmodule
